[rtl/lph_pkg.sv]
// Shared types and codes for the linear probe hash table.
// Holds the sequencer state enum, request codes and slot tag codes; no dependencies.
package lph_pkg;

  localparam int unsigned HASH_BITS = 32;
  localparam int unsigned HASH_CW   = 5;   // bits to count through one hash word

  typedef enum logic [1:0] {
    REQ_GET = 2'd0,
    REQ_SET = 2'd1,
    REQ_DEL = 2'd2,
    REQ_NOP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2,
    TAG_RSVD  = 2'd3
  } tag_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MOD,
    S_P_RD,
    S_P_CHK,
    S_RESP
  } state_e;

endpackage

[rtl/linear_probe_hash_table.sv]
// Linear probe hash table: sequencer, bit-serial modulo unit and slot memory.
// Depends on lph_pkg for request, tag and state codes.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the request type
//   (get, set, delete), tdata the key, its 32-bit hash and the value to store.
//   Each request yields exactly one transfer on the m_axis channel: tuser holds
//   the status flag (table full) and the hit/new flag, tdata the value read.
//   One request is worked at a time; s_axis_tready is high only while idle.
//   A request answered without probing goes from decode straight to the response
//   step; else the hash modulo runs (one quotient bit a cycle), then each slot
//   probed is read from memory and then checked, then the response is given. A set
//   that grows the table also sweeps the new bank slot by slot and walks the old
//   bank, reading then checking each slot, with a modulo and probe per live entry moved.
//   The single registered read port of the slot memory sets the probe pace.
//   Reset clears only the control state; slot tags need no clearing pass, as
//   every bank is swept empty when it becomes active. A stalled result is held
//   in the output register; the sequencer waits in its response step until the
//   register is free, so nothing is lost.
module linear_probe_hash_table
  import lph_pkg::*;
#(
  parameter int unsigned MAX_SLOTS  = 1024,
  parameter int unsigned MIN_SLOTS  = 8,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] lookup_key, [95:64] key_hash, [159:96] write_value
  input  logic [159:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] read_value
  output logic [63:0]  m_axis_tdata,
  // [0] status, [1] hit_or_new
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;  // slot index
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);                     // slot count
  localparam int unsigned RW = CW + 1;                                   // remainder
  localparam int unsigned DW = $clog2(2 * MAX_SLOTS);                    // memory address
  localparam int unsigned GW = CW + 3;                                   // load compare
  localparam int unsigned K0 = 0;
  localparam int unsigned V0 = KEY_BITS;
  localparam int unsigned H0 = KEY_BITS + VALUE_BITS;
  localparam int unsigned T0 = H0 + HASH_BITS;
  localparam int unsigned EW = T0 + 2;

  // Slot memory: both banks, one entry per slot {tag, hash, value, key}
  logic [EW-1:0] mem_q [2*MAX_SLOTS];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [DW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  state_e                state_q, state_d;
  logic [1:0]            req_q, req_d;
  logic [KEY_BITS-1:0]   key_q, key_d, mv_key_q, mv_key_d;
  logic [HASH_BITS-1:0]  hash_q, hash_d, mv_hash_q, mv_hash_d;
  logic [VALUE_BITS-1:0] val_q, val_d, mv_val_q, mv_val_d;
  logic                  bank_q, bank_d;
  logic [CW-1:0]         n_q, n_d, used_q, used_d, new_n_q, new_n_d;
  logic [CW-1:0]         live_q, live_d, cnt_q, cnt_d, c_q, c_d;
  logic                  reh_q, reh_d;      // probing for a rehash move
  logic [RW-1:0]         rem_q, rem_d;
  logic [HASH_CW-1:0]    bit_q, bit_d;
  logic [AW-1:0]         i_q, i_d, first_q, first_d;
  logic                  seen_q, seen_d;
  logic                  res_st_q, res_st_d, res_hit_q, res_hit_d;
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;
  logic                  ov_q, ov_d, ost_q, ost_d, ohit_q, ohit_d;
  logic [VALUE_BITS-1:0] oval_q, oval_d;

  logic                  pbank;
  logic [CW-1:0]         probe_n;
  logic [KEY_BITS-1:0]   pkey;
  logic [HASH_BITS-1:0]  phash;
  logic [RW-1:0]         rem_sh;
  logic [GW-1:0]         g_lhs, g_rhs;
  logic [CW:0]           dbl_n;
  logic [1:0]            rd_tag;

  assign pbank   = reh_q ? ~bank_q : bank_q;
  assign probe_n = reh_q ? new_n_q : n_q;
  assign pkey    = reh_q ? mv_key_q : key_q;
  assign phash   = reh_q ? mv_hash_q : hash_q;
  assign rem_sh  = {rem_q[RW-2:0], phash[bit_q]};
  assign g_lhs   = (GW'(used_q) + GW'(1)) << 2;
  assign g_rhs   = GW'(3) * GW'(n_q);
  assign dbl_n   = {n_q, 1'b0};
  assign rd_tag  = rd_q[T0 +: 2];

  function automatic logic [DW-1:0] slot_addr(input logic bk, input logic [AW-1:0] s);
    slot_addr = DW'(s) + (bk ? DW'(MAX_SLOTS) : DW'(0));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bank_q  <= 1'b0;
      n_q     <= '0;
      used_q  <= '0;
      ov_q    <= 1'b0;
      reh_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      n_q     <= n_d;
      used_q  <= used_d;
      ov_q    <= ov_d;
      reh_q   <= reh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    key_q     <= key_d;
    hash_q    <= hash_d;
    val_q     <= val_d;
    mv_key_q  <= mv_key_d;
    mv_hash_q <= mv_hash_d;
    mv_val_q  <= mv_val_d;
    new_n_q   <= new_n_d;
    live_q    <= live_d;
    cnt_q     <= cnt_d;
    c_q       <= c_d;
    rem_q     <= rem_d;
    bit_q     <= bit_d;
    i_q       <= i_d;
    first_q   <= first_d;
    seen_q    <= seen_d;
    res_st_q  <= res_st_d;
    res_hit_q <= res_hit_d;
    res_val_q <= res_val_d;
    ost_q     <= ost_d;
    ohit_q    <= ohit_d;
    oval_q    <= oval_d;
  end

  always_comb begin
    logic          scan_adv, commit, fin_free, fin_hit, fin_none, was_empty;
    logic [AW-1:0] where_s, nxt_i;
    logic [CW-1:0] live_n;
    state_d   = state_q;
    req_d     = req_q;
    key_d     = key_q;
    hash_d    = hash_q;
    val_d     = val_q;
    mv_key_d  = mv_key_q;
    mv_hash_d = mv_hash_q;
    mv_val_d  = mv_val_q;
    bank_d    = bank_q;
    n_d       = n_q;
    used_d    = used_q;
    new_n_d   = new_n_q;
    live_d    = live_q;
    cnt_d     = cnt_q;
    c_d       = c_q;
    reh_d     = reh_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    i_d       = i_q;
    first_d   = first_q;
    seen_d    = seen_q;
    res_st_d  = res_st_q;
    res_hit_d = res_hit_q;
    res_val_d = res_val_q;
    ov_d      = ov_q & ~m_axis_tready;
    ost_d     = ost_q;
    ohit_d    = ohit_q;
    oval_d    = oval_q;
    we        = 1'b0;
    waddr     = slot_addr(pbank, i_q);
    wdata     = {TAG_LIVE, phash, (reh_q ? mv_val_q : val_q), pkey};
    raddr     = slot_addr(pbank, i_q);
    scan_adv  = 1'b0;
    commit    = 1'b0;
    fin_free  = 1'b0;
    fin_hit   = 1'b0;
    fin_none  = 1'b0;
    was_empty = 1'b0;
    where_s   = i_q;
    live_n    = live_q;
    nxt_i     = (CW'(i_q) + CW'(1) == probe_n) ? '0 : i_q + AW'(1);
    s_axis_tready = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d   = s_axis_tuser;
          key_d   = s_axis_tdata[KEY_BITS-1:0];
          hash_d  = s_axis_tdata[95:64];
          val_d   = s_axis_tdata[96 +: VALUE_BITS];
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_st_d  = 1'b0;
        res_hit_d = 1'b0;
        res_val_d = '0;
        reh_d     = 1'b0;
        rem_d     = '0;
        bit_d     = HASH_CW'(HASH_BITS - 1);
        case (req_q)
          REQ_GET, REQ_DEL: begin
            state_d = (used_q == '0) ? S_RESP : S_MOD;
          end
          REQ_SET: begin
            if (g_lhs > g_rhs) begin
              if (n_q >= CW'(MAX_SLOTS)) begin
                res_st_d = 1'b1;
                state_d  = S_RESP;
              end else begin
                // Grow: minimum size first, then double, capped at the maximum
                if (n_q < CW'(MIN_SLOTS)) begin
                  new_n_d = CW'(MIN_SLOTS);
                end else if (dbl_n > (CW+1)'(MAX_SLOTS)) begin
                  new_n_d = CW'(MAX_SLOTS);
                end else begin
                  new_n_d = dbl_n[CW-1:0];
                end
                cnt_d   = '0;
                state_d = S_CLEAR;
              end
            end else begin
              state_d = S_MOD;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_CLEAR: begin
        // Sweep the spare bank empty, one slot a cycle
        we    = 1'b1;
        waddr = slot_addr(~bank_q, cnt_q[AW-1:0]);
        wdata = '0;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q + CW'(1) == new_n_q) begin
          cnt_d  = '0;
          live_d = '0;
          live_n = '0;
          if (n_q == '0) begin
            commit = 1'b1;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        raddr   = slot_addr(bank_q, cnt_q[AW-1:0]);
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_tag == TAG_LIVE) begin
          mv_key_d  = rd_q[K0 +: KEY_BITS];
          mv_val_d  = rd_q[V0 +: VALUE_BITS];
          mv_hash_d = rd_q[H0 +: HASH_BITS];
          reh_d     = 1'b1;
          rem_d     = '0;
          bit_d     = HASH_CW'(HASH_BITS - 1);
          state_d   = S_MOD;
        end else begin
          scan_adv = 1'b1;
        end
      end
      S_MOD: begin
        // One restoring remainder step per cycle, hash MSB first
        rem_d = (rem_sh >= RW'(probe_n)) ? rem_sh - RW'(probe_n) : rem_sh;
        bit_d = bit_q - HASH_CW'(1);
        if (bit_q == '0) begin
          i_d     = rem_d[AW-1:0];
          c_d     = '0;
          seen_d  = 1'b0;
          state_d = S_P_RD;
        end
      end
      S_P_RD: begin
        state_d = S_P_CHK;
      end
      S_P_CHK: begin
        if (rd_tag == TAG_EMPTY) begin
          fin_free  = 1'b1;
          was_empty = ~seen_q;
          where_s   = seen_q ? first_q : i_q;
        end else if (rd_tag == TAG_LIVE && rd_q[K0 +: KEY_BITS] == pkey) begin
          fin_hit = 1'b1;
        end else begin
          if (rd_tag == TAG_TOMB && !seen_q) begin
            seen_d  = 1'b1;
            first_d = i_q;
          end
          i_d     = nxt_i;
          c_d     = c_q + CW'(1);
          state_d = S_P_RD;
          if (c_q + CW'(1) == probe_n) begin
            if (seen_d) begin
              fin_free = 1'b1;
              where_s  = first_d;
            end else begin
              fin_none = 1'b1;
            end
          end
        end

        if (reh_q) begin
          // Move a live entry into the new bank
          if (fin_free || fin_hit) begin
            we     = 1'b1;
            waddr  = slot_addr(pbank, where_s);
            live_n = live_q + CW'(1);
            live_d = live_n;
          end
          if (fin_free || fin_hit || fin_none) begin
            scan_adv = 1'b1;
          end
        end else if (fin_free || fin_hit || fin_none) begin
          state_d = S_RESP;
          case (req_q)
            REQ_GET: begin
              res_hit_d = fin_hit;
              res_val_d = fin_hit ? rd_q[V0 +: VALUE_BITS] : '0;
            end
            REQ_DEL: begin
              res_hit_d = fin_hit;
              if (fin_hit) begin
                we    = 1'b1;
                wdata = {TAG_TOMB, rd_q[T0-1:0]};
              end
            end
            REQ_SET: begin
              if (fin_none) begin
                res_st_d = 1'b1;
              end else begin
                we        = 1'b1;
                waddr     = slot_addr(pbank, where_s);
                res_hit_d = fin_free;
                if (fin_free && was_empty) begin
                  used_d = used_q + CW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        // Hold until the output register is free
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          ost_d   = res_st_q;
          ohit_d  = res_hit_q;
          oval_d  = res_val_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (scan_adv) begin
      cnt_d   = cnt_q + CW'(1);
      reh_d   = 1'b0;
      state_d = S_SCAN_RD;
      if (cnt_q + CW'(1) == n_q) begin
        commit = 1'b1;
      end
    end
    if (commit) begin
      // Switch to the new bank and continue with the pending set
      bank_d  = ~bank_q;
      n_d     = new_n_q;
      used_d  = live_n;
      reh_d   = 1'b0;
      rem_d   = '0;
      bit_d   = HASH_CW'(HASH_BITS - 1);
      state_d = S_MOD;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = 64'(oval_q);
  assign m_axis_tuser  = {ohit_q, ost_q};

  // The used count never exceeds the slot count
  a_used_le_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= n_q) else $error("used count above slot count");

  // A probe never visits more slots than the table holds
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_P_CHK |-> c_q < probe_n) else $error("probe overran table");

  // The modulo unit never runs against an empty table
  a_mod_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> probe_n != '0) else $error("modulo by zero");

  // A finished result waiting for the receiver is not overwritten
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && ov_q && !m_axis_tready) |=> state_q == S_RESP)
    else $error("response left while output busy");

endmodule
